/* rtl/core/orba_pkg.sv */
// orba_pkg: shared sizes, microcode types and the control store of the batch averager
// used by every module under rtl/core except orba_ram; depends on nothing
package orba_pkg;

  // store geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int SMP_W  = 8;
  localparam int THR_W  = 7;
  localparam int AVG_W  = 7;
  localparam logic [THR_W-1:0] THR_RESET = 7'd3;

  // datapath widths: sum of positives, signed bounds, rounding divider
  localparam int SUM_W  = $clog2(127 * DEPTH + 1);
  localparam int BND_W  = SUM_W + 2;
  localparam int NUM_W  = $clog2(255 * DEPTH + 1);
  localparam int DEN_W  = CNT_W + 1;
  localparam int DSH_W  = DEN_W + AVG_W - 1;
  localparam int DIV_W  = (NUM_W > DSH_W) ? NUM_W : DSH_W;
  localparam int DCNT_W = $clog2(AVG_W);

  // microcode
  localparam int UPC_W  = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PASS1,
    RD_PASS2
  } rd_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_MORE,
    JMP_N1_ZERO,
    JMP_N2_ZERO,
    JMP_DIV_MORE
  } jmp_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_RST_IDX,
    OP_BOUNDS,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DONE_OK,
    OP_DONE_FAIL
  } op_t;

  typedef struct packed {
    op_t  op;
    rd_t  rd;
    jmp_t jmp;
    upc_t target;
    logic last;
  } uword_t;

  typedef struct packed {
    logic more;
    logic n1_zero;
    logic n2_zero;
    logic div_more;
  } dp_status_t;

  // step addresses of the batch program
  localparam upc_t UPC_CLEAR = 4'd0;
  localparam upc_t UPC_PASS1 = 4'd1;
  localparam upc_t UPC_DRAIN1 = 4'd2;
  localparam upc_t UPC_BOUNDS = 4'd3;
  localparam upc_t UPC_PASS2 = 4'd4;
  localparam upc_t UPC_DRAIN2 = 4'd5;
  localparam upc_t UPC_DIVINIT = 4'd6;
  localparam upc_t UPC_DIVSTEP = 4'd7;
  localparam upc_t UPC_OK = 4'd8;
  localparam upc_t UPC_FAIL = 4'd9;

  localparam uword_t UWORD_NOP = '{op: OP_NOP, rd: RD_NONE, jmp: JMP_NONE,
                                   target: UPC_CLEAR, last: 1'b1};

  // control store: one word per step
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    unique case (pc)
      UPC_CLEAR:   w = '{op: OP_CLEAR, rd: RD_NONE, jmp: JMP_NONE,
                         target: UPC_CLEAR, last: 1'b0};
      UPC_PASS1:   w = '{op: OP_NOP, rd: RD_PASS1, jmp: JMP_MORE,
                         target: UPC_PASS1, last: 1'b0};
      UPC_DRAIN1:  w = '{op: OP_RST_IDX, rd: RD_NONE, jmp: JMP_NONE,
                         target: UPC_CLEAR, last: 1'b0};
      UPC_BOUNDS:  w = '{op: OP_BOUNDS, rd: RD_NONE, jmp: JMP_N1_ZERO,
                         target: UPC_FAIL, last: 1'b0};
      UPC_PASS2:   w = '{op: OP_NOP, rd: RD_PASS2, jmp: JMP_MORE,
                         target: UPC_PASS2, last: 1'b0};
      UPC_DRAIN2:  w = '{op: OP_RST_IDX, rd: RD_NONE, jmp: JMP_NONE,
                         target: UPC_CLEAR, last: 1'b0};
      UPC_DIVINIT: w = '{op: OP_DIV_INIT, rd: RD_NONE, jmp: JMP_N2_ZERO,
                         target: UPC_FAIL, last: 1'b0};
      UPC_DIVSTEP: w = '{op: OP_DIV_STEP, rd: RD_NONE, jmp: JMP_DIV_MORE,
                         target: UPC_DIVSTEP, last: 1'b0};
      UPC_OK:      w = '{op: OP_DONE_OK, rd: RD_NONE, jmp: JMP_NONE,
                         target: UPC_CLEAR, last: 1'b1};
      UPC_FAIL:    w = '{op: OP_DONE_FAIL, rd: RD_NONE, jmp: JMP_NONE,
                         target: UPC_CLEAR, last: 1'b1};
      default:     w = UWORD_NOP;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/orba_ram.sv */
// orba_ram: generic simple dual-port ram, one write and one registered read port
// stand-alone, no package needed
module orba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/orba_sequencer.sv */
// orba_sequencer: micro program counter stepping through the control store
// depends on orba_pkg for the control word, status struct and rom function
module orba_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                launch,
  input  orba_pkg::dp_status_t status,
  output orba_pkg::uword_t    ctrl,
  output logic                running
);
  import orba_pkg::*;

  upc_t   pc;
  uword_t word;
  logic   taken;

  assign word = ucode_rom(pc);
  assign ctrl = running ? word : UWORD_NOP;

  // conditional jump decode
  always_comb begin
    unique case (word.jmp)
      JMP_NONE:     taken = 1'b0;
      JMP_MORE:     taken = status.more;
      JMP_N1_ZERO:  taken = status.n1_zero;
      JMP_N2_ZERO:  taken = status.n2_zero;
      JMP_DIV_MORE: taken = status.div_more;
      default:      taken = 1'b0;
    endcase
  end

  // program counter and run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= UPC_CLEAR;
    end else if (!running) begin
      if (launch) begin
        running <= 1'b1;
        pc      <= UPC_CLEAR;
      end
    end else if (word.last) begin
      running <= 1'b0;
      pc      <= UPC_CLEAR;
    end else if (taken) begin
      pc <= word.target;
    end else begin
      pc <= pc + 1'b1;
    end
  end

endmodule

/* rtl/core/orba_datapath.sv */
// orba_datapath: store read index, two accumulation passes, window bounds,
// restoring divider for the rounded mean and the result registers
// depends on orba_pkg for widths and control word types
module orba_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  orba_pkg::uword_t               ctrl,
  input  logic [orba_pkg::THR_W-1:0]     thr,
  input  logic [orba_pkg::SMP_W-1:0]     rdata,
  output logic [orba_pkg::IDX_W-1:0]     raddr,
  output orba_pkg::dp_status_t           status,
  output logic                           done,
  output logic [orba_pkg::AVG_W-1:0]     average,
  output logic                           batch_failed
);
  import orba_pkg::*;

  logic [IDX_W-1:0]         idx;
  rd_t                      pend;
  logic [SUM_W-1:0]         s1;
  logic [SUM_W-1:0]         s2;
  logic [CNT_W-1:0]         n1;
  logic [CNT_W-1:0]         n2;
  logic signed [BND_W-1:0]  lo;
  logic signed [BND_W-1:0]  hi;
  logic [DIV_W-1:0]         rem;
  logic [DIV_W-1:0]         dsh;
  logic [AVG_W-1:0]         quo;
  logic [DCNT_W-1:0]        dcnt;

  logic                     x_pos;
  logic [AVG_W-1:0]         xmag;
  logic [AVG_W+CNT_W-1:0]   xn_full;
  logic signed [BND_W-1:0]  xn;
  logic                     keep;
  logic [THR_W+CNT_W-1:0]   tn_full;
  logic [SUM_W-1:0]         tn;

  assign raddr = idx;

  // sample from the store, positive test and scaled value
  assign x_pos   = !rdata[SMP_W-1] && (rdata != '0);
  assign xmag    = rdata[AVG_W-1:0];
  assign xn_full = xmag * n1;
  assign xn      = $signed({2'b00, SUM_W'(xn_full)});
  assign keep    = x_pos && (lo < xn) && (xn < hi);

  // threshold scaled by the positive count
  assign tn_full = thr * n1;
  assign tn      = SUM_W'(tn_full);

  assign status.more     = (idx != IDX_W'(DEPTH - 1));
  assign status.n1_zero  = (n1 == '0);
  assign status.n2_zero  = (n2 == '0);
  assign status.div_more = (dcnt != '0);

  // control: read index, pending read tag, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      pend         <= RD_NONE;
      done         <= 1'b0;
      average      <= '0;
      batch_failed <= 1'b0;
    end else begin
      pend <= ctrl.rd;
      done <= 1'b0;
      if (ctrl.rd != RD_NONE) begin
        idx <= idx + 1'b1;
      end
      case (ctrl.op) inside
        OP_CLEAR, OP_RST_IDX: idx <= '0;
        OP_DONE_OK: begin
          average      <= quo;
          batch_failed <= 1'b0;
          done         <= 1'b1;
        end
        OP_DONE_FAIL: begin
          batch_failed <= 1'b1;
          done         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // accumulators, bounds and divider
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CLEAR: begin
        s1 <= '0;
        n1 <= '0;
        s2 <= '0;
        n2 <= '0;
      end
      OP_BOUNDS: begin
        lo <= $signed({2'b00, s1}) - $signed({2'b00, tn});
        hi <= $signed({2'b00, s1}) + $signed({2'b00, tn});
      end
      OP_DIV_INIT: begin
        rem  <= DIV_W'({s2, 1'b0}) + DIV_W'(n2);
        dsh  <= DIV_W'({n2, 1'b0}) << (AVG_W - 1);
        quo  <= '0;
        dcnt <= DCNT_W'(AVG_W - 1);
      end
      OP_DIV_STEP: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[AVG_W-2:0], 1'b1};
        end else begin
          quo <= {quo[AVG_W-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        dcnt <= dcnt - 1'b1;
      end
      default: ;
    endcase
    // store data arrives in the cycle after its read
    if (pend == RD_PASS1 && x_pos) begin
      s1 <= s1 + SUM_W'(xmag);
      n1 <= n1 + 1'b1;
    end
    if (pend == RD_PASS2 && keep) begin
      s2 <= s2 + SUM_W'(xmag);
      n2 <= n2 + 1'b1;
    end
  end

endmodule

/* rtl/core/outlier_rejecting_batch_average.sv */
// outlier_rejecting_batch_average: top level, sample store, write position,
// threshold register and the microcoded batch engine
// depends on orba_pkg, orba_ram, orba_sequencer, orba_datapath
//
// usage:
//   samples enter on the command channel: a beat is taken at a rising edge
//   with start high and busy low. each sample goes into a 16-entry store.
//   the sample that fills the store starts batch processing and raises busy
//   on the next cycle; samples that do not fill the store leave busy low.
//   batch processing runs a 10-step micro program: clear, a read pass over
//   the store for the positive mean, bounds, a second pass keeping samples
//   inside the window, then a 7-step restoring divide for the rounded mean.
//   busy stays high through the steps that run; the store port gives one read
//   per cycle and the divider one bit per cycle. a batch with no positive
//   sample stops after bounds, one with no survivor after the divide setup.
//   done pulses for one cycle with average and batch_failed in the same
//   cycle that busy falls; the receiver cannot stall.
//   reject_threshold is written on the cfg channel (valid and ready) while idle.
//   reset (rst, synchronous) restarts the store fill, zeroes the held average, threshold 3.
module outlier_rejecting_batch_average (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [orba_pkg::SMP_W-1:0] sample,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [orba_pkg::THR_W-1:0]   reject_threshold,
  output logic                         done,
  output logic [orba_pkg::AVG_W-1:0]   average,
  output logic                         batch_failed
);
  import orba_pkg::*;

  logic [IDX_W-1:0] wr_pos;
  logic [THR_W-1:0] thr;
  logic             accept;
  logic             launch;
  logic             running;
  logic [IDX_W-1:0] raddr;
  logic [SMP_W-1:0] rdata;
  uword_t           ctrl;
  dp_status_t       status;

  assign busy      = running;
  assign cfg_ready = !running;
  assign accept    = start && !busy;
  assign launch    = accept && (wr_pos == IDX_W'(DEPTH - 1));

  // write position and threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos <= '0;
      thr    <= THR_RESET;
    end else begin
      if (accept) begin
        wr_pos <= launch ? '0 : wr_pos + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        thr <= reject_threshold;
      end
    end
  end

  // sample store
  orba_ram #(
    .WIDTH(SMP_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept),
    .waddr(wr_pos),
    .wdata(sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  // micro program sequencer
  orba_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .launch (launch),
    .status (status),
    .ctrl   (ctrl),
    .running(running)
  );

  // batch datapath
  orba_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .thr         (thr),
    .rdata       (rdata),
    .raddr       (raddr),
    .status      (status),
    .done        (done),
    .average     (average),
    .batch_failed(batch_failed)
  );

`ifndef SYNTH
  // a result only ends a batch that was running
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running batch");

  // the filling sample starts the batch
  a_fill_launches: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && wr_pos == IDX_W'(DEPTH - 1)) |=> busy)
    else $error("full store did not start batch processing");

  // no samples are written while the store is being read
  a_pos_frozen: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> $stable(wr_pos))
    else $error("write position moved during a batch");
`endif

endmodule

/* sim/outlier_rejecting_batch_average_tb.sv */
// outlier_rejecting_batch_average_tb: self-checking bench for the outlier-rejecting batch averager
// directed batch table, then random batches checked against a built-in batch predictor
// depends on orba_pkg and outlier_rejecting_batch_average
module outlier_rejecting_batch_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import orba_pkg::*;

  localparam int RANDOM_ITEMS  = 1770;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 64;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             failed;
  } batch_result_t;

  // one directed batch: odd_cnt copies of odd, then base for the rest
  typedef struct {
    logic [THR_W-1:0]        thr;
    logic signed [SMP_W-1:0] odd;
    int                      odd_cnt;
    logic signed [SMP_W-1:0] base;
    bit                      has_exp;
    logic [AVG_W-1:0]        exp_avg;
    bit                      exp_fail;
  } batch_row_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [SMP_W-1:0] sample = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [THR_W-1:0]        reject_threshold = THR_RESET;
  logic                    done;
  logic [AVG_W-1:0]        average;
  logic                    batch_failed;

  // predictor state
  logic signed [SMP_W-1:0] window_store [DEPTH];
  int                      fill_pos;
  logic [AVG_W-1:0]        model_avg;
  logic [THR_W-1:0]        model_thr;
  batch_result_t           avg_expect_q[$];
  batch_result_t           last_result;

  int mismatches      = 0;
  int samples_taken   = 0;
  int batches_checked = 0;
  int failed_batches  = 0;
  int cfg_writes      = 0;
  int stall_cycles    = 0;

  batch_row_t directed_rows [8] = '{
    '{7'd3,   -8'sd128, 8,  8'sd0,   1'b1, 7'd0,   1'b1},  // no positive sample
    '{7'd3,   8'sd127,  0,  8'sd127, 1'b1, 7'd127, 1'b0},  // all at the top
    '{7'd0,   8'sd50,   0,  8'sd50,  1'b1, 7'd127, 1'b1},  // empty window keeps held value
    '{7'd127, -8'sd1,   4,  8'sd1,   1'b1, 7'd1,   1'b0},  // widest window, negatives dropped
    '{7'd3,   8'sd100,  1,  8'sd20,  1'b0, 7'd0,   1'b0},  // outlier drags mean off the cluster
    '{7'd10,  8'sd100,  1,  8'sd20,  1'b0, 7'd0,   1'b0},  // outlier rejected, cluster kept
    '{7'd127, 8'sd127,  8,  -8'sd128, 1'b1, 7'd127, 1'b0}, // extremes mixed
    '{7'd5,   8'sd10,   8,  8'sd11,  1'b1, 7'd11,  1'b0}   // mean of 10.5 rounds up
  };

  outlier_rejecting_batch_average dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .sample           (sample),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .reject_threshold (reject_threshold),
    .done             (done),
    .average          (average),
    .batch_failed     (batch_failed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(string what, int exp_v, int act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
  endtask

  // store one sample; on a full store, work out the batch average
  function automatic void store_sample_and_average(logic signed [SMP_W-1:0] x);
    int pos_sum;
    int pos_cnt;
    int kept_sum;
    int kept_cnt;
    int thr;
    int xv;
    int xn;
    int rounded;
    batch_result_t r;
    window_store[fill_pos] = x;
    fill_pos++;
    if (fill_pos < DEPTH) return;
    fill_pos = 0;
    pos_sum  = 0;
    pos_cnt  = 0;
    kept_sum = 0;
    kept_cnt = 0;
    thr      = int'(model_thr);
    for (int i = 0; i < DEPTH; i++) begin
      xv = int'(window_store[i]);
      if (xv > 0) begin
        pos_sum += xv;
        pos_cnt++;
      end
    end
    // exact window test, multiplied out by the positive count
    for (int i = 0; i < DEPTH; i++) begin
      xv = int'(window_store[i]);
      xn = xv * pos_cnt;
      if (pos_cnt > 0 && xv > 0 && pos_sum - thr * pos_cnt < xn && xn < pos_sum + thr * pos_cnt) begin
        kept_sum += xv;
        kept_cnt++;
      end
    end
    r.failed = 1'b1;
    if (kept_cnt > 0) begin
      rounded   = (2 * kept_sum + kept_cnt) / (2 * kept_cnt);
      model_avg = rounded[AVG_W-1:0];
      r.failed  = 1'b0;
    end
    r.average = model_avg;
    avg_expect_q.push_back(r);
  endfunction

  // monitor: track config and sample beats, check each result
  always @(posedge clk) begin
    batch_result_t exp_r;
    if (rst) begin
      fill_pos  = 0;
      model_avg = '0;
      model_thr = THR_RESET;
      avg_expect_q.delete();
    end else begin
      if (done) begin
        if (avg_expect_q.size() == 0) begin
          note_mismatch("result with nothing pending", 0, 1);
        end else begin
          exp_r = avg_expect_q.pop_front();
          if (average !== exp_r.average)
            note_mismatch("average", exp_r.average, average);
          if (batch_failed !== exp_r.failed)
            note_mismatch("batch_failed", exp_r.failed, batch_failed);
          batches_checked++;
          if (exp_r.failed) failed_batches++;
        end
        last_result = '{average, batch_failed};
      end
      if (cfg_valid && cfg_ready) begin
        model_thr = reject_threshold;
        cfg_writes++;
      end
      if (start && !busy) begin
        samples_taken++;
        store_sample_and_average(sample);
      end
    end
  end

  // watchdog on cycles with no beat of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("outlier_rejecting_batch_average_tb failed");
        $finish;
      end
    end
  end

  // one sample beat after an optional gap; start stays high for back-to-back beats
  task automatic feed_sample(logic signed [SMP_W-1:0] x, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    sample <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // idle the command side until every pending batch result is in
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (avg_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] t);
    drain_results();
    repeat ($urandom_range(0, 9)) @(posedge clk);
    cfg_valid        <= 1'b1;
    reject_threshold <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly clustered readings, with some full-range noise and cold readings
  function automatic logic signed [SMP_W-1:0] draw_sample(int center, int spread, bit cold);
    int v;
    int pick;
    pick = $urandom_range(0, 99);
    if (cold)
      v = -int'($urandom_range(0, 128));
    else if (pick < 6)
      v = int'($urandom_range(0, 255)) - 128;
    else if (pick < 10)
      v = -int'($urandom_range(0, 128));
    else
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return v[SMP_W-1:0];
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return THR_W'($urandom_range(0, 127));
    return THR_W'($urandom_range(1, 15));
  endfunction

  initial begin
    int  fed;
    int  rand_fed;
    int  gap;
    int  center;
    int  spread;
    int  phase_len;
    bit  cold;
    bit  burst;
    fed      = 0;
    rand_fed = 0;
    center   = 1;
    spread   = 0;
    cold     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed batches
    foreach (directed_rows[r]) begin
      write_threshold(directed_rows[r].thr);
      for (int k = 0; k < DEPTH; k++)
        feed_sample(k < directed_rows[r].odd_cnt ? directed_rows[r].odd : directed_rows[r].base,
                    $urandom_range(0, 9));
      fed += DEPTH;
      drain_results();
      if (directed_rows[r].has_exp) begin
        if (last_result.average !== directed_rows[r].exp_avg)
          note_mismatch("directed average", directed_rows[r].exp_avg, last_result.average);
        if (last_result.failed !== directed_rows[r].exp_fail)
          note_mismatch("directed batch_failed", directed_rows[r].exp_fail, last_result.failed);
      end
    end

    // random phases, each under its own threshold
    while (rand_fed < RANDOM_ITEMS) begin
      write_threshold(pick_threshold());
      phase_len = $urandom_range(8, 64);
      burst     = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if (fed % DEPTH == 0) begin
          cold   = ($urandom_range(0, 9) == 0);
          center = $urandom_range(1, 127);
          spread = $urandom_range(0, 12);
        end
        gap = burst ? 0 : $urandom_range(0, 9);
        feed_sample(draw_sample(center, spread, cold), gap);
        fed++;
        rand_fed++;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples in %0d batches, %0d with no survivor, %0d threshold writes",
             samples_taken, batches_checked, failed_batches, cfg_writes);
    if (mismatches != 0)
      $display("%0d mismatches in total", mismatches);
    if (mismatches == 0 && avg_expect_q.size() == 0)
      $display("outlier_rejecting_batch_average_tb passed");
    else
      $display("outlier_rejecting_batch_average_tb failed");
    $finish;
  end

endmodule
